// ===== rtl/rhh_pkg.sv =====
// Shared types, codes and helpers for the Robin Hood hash table.
// Used by rhh_engine and robin_hood_hash_table.
package rhh_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BADLEN   = 2'd3;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] hash;
		logic [31:0] data;
		logic [3:0]  len;
	} rhh_payload_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] hash;
		logic [63:0] key;
		logic [3:0]  key_len;
		logic [31:0] data;
	} rhh_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_data;
		logic [7:0]  hit_slot;
		logic [8:0]  entry_count;
		logic [7:0]  max_distance;
	} rhh_result_t;

	function automatic logic [63:0] key_mask(input logic [63:0] key, input logic [3:0] len);
		logic [63:0] k;
		k = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				k[b*8 +: 8] = key[b*8 +: 8];
			end
		end
		return k;
	endfunction

endpackage

// ===== rtl/rhh_mem.sv =====
// Slot memory: one write port and one read port, read data registered.
// A read of the entry written in the same cycle returns the new data.
module rhh_mem #(
	parameter int AW = 8,
	parameter int DW = 140
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra,
	output logic [DW-1:0] rd
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (we && wa == ra) begin
			rd_q <= wd;
		end else begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ===== rtl/rhh_engine.sv =====
// Probe sequencer: clears the slot memory after reset, then walks it one
// slot per cycle for insert, find and backward-shift remove. Uses rhh_pkg.
module rhh_engine #(
	parameter int AW = 8,
	parameter int KEY_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  rhh_pkg::rhh_req_t     req,
	output logic                  req_stall,
	output logic                  res_valid,
	output rhh_pkg::rhh_result_t  res,
	input  logic                  res_take,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_wa,
	output rhh_pkg::rhh_payload_t mem_wpay,
	output logic [AW-1:0]         mem_wdist,
	output logic [AW-1:0]         mem_ra,
	input  rhh_pkg::rhh_payload_t mem_rpay,
	input  logic [AW-1:0]         mem_rdist
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_INSERT = 6'b000100,
		S_FIND   = 6'b001000,
		S_SHIFT  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	localparam logic [AW-1:0] LAST = AW'((2**AW) - 1);
	localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(2**AW);

	state_t                state_q, state_d;
	logic [AW-1:0]         pos_q, pos_d, fit_q, fit_d, cd_q, cd_d, maxd_q, maxd_d;
	logic [AW:0]           cnt_q, cnt_d, occ_q, occ_d;
	rhh_pkg::rhh_payload_t car_q, car_d;
	logic [1:0]            kind_q, kind_d, status_q, status_d;
	logic [31:0]           rdata_q, rdata_d;
	logic [AW-1:0]         hit_q, hit_d;
	logic [AW-1:0]         ncd;
	logic                  lenbad, match;
	rhh_pkg::rhh_payload_t empty;
	logic [AW+7:0]         hit_x;
	logic [AW+9:0]         occ_x;
	logic [AW+7:0]         max_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pos_q   <= '0;
			cnt_q   <= '0;
			occ_q   <= '0;
			maxd_q  <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			occ_q   <= occ_d;
			maxd_q  <= maxd_d;
		end
	end

	always_ff @(posedge clk) begin
		fit_q    <= fit_d;
		cd_q     <= cd_d;
		car_q    <= car_d;
		kind_q   <= kind_d;
		status_q <= status_d;
		rdata_q  <= rdata_d;
		hit_q    <= hit_d;
	end

	always_comb begin
		empty       = mem_rpay;
		empty.len   = '0;
		lenbad      = (req.key_len == 4'd0) || ({28'd0, req.key_len} > KEY_BYTES);
		match       = (mem_rpay.len == car_q.len) && (mem_rpay.hash == car_q.hash) &&
		              (mem_rpay.key == car_q.key);
		ncd         = '0;
		state_d     = state_q;
		pos_d       = pos_q;
		cnt_d       = cnt_q;
		occ_d       = occ_q;
		maxd_d      = maxd_q;
		fit_d       = fit_q;
		cd_d        = cd_q;
		car_d       = car_q;
		kind_d      = kind_q;
		status_d    = status_q;
		rdata_d     = rdata_q;
		hit_d       = hit_q;
		req_stall   = 1'b1;
		res_valid   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = pos_q;
		mem_wpay    = car_q;
		mem_wdist   = cd_q;
		mem_ra      = pos_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_wpay = empty;
				pos_d    = pos_q + 1'b1;
				if (pos_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				mem_ra    = req.hash[AW-1:0];
				if (req_valid) begin
					kind_d       = req.kind;
					car_d.key    = rhh_pkg::key_mask(req.key, req.key_len);
					car_d.hash   = req.hash;
					car_d.data   = req.data;
					car_d.len    = req.key_len;
					pos_d        = req.hash[AW-1:0];
					cd_d         = '0;
					cnt_d        = '0;
					rdata_d      = '0;
					hit_d        = '0;
					status_d     = rhh_pkg::ST_OK;
					if (lenbad) begin
						status_d = rhh_pkg::ST_BADLEN;
						state_d  = S_DONE;
					end else if (req.kind == rhh_pkg::KIND_INSERT) begin
						if (occ_q == DEPTH_CNT) begin
							status_d = rhh_pkg::ST_FULL;
							state_d  = S_DONE;
						end else begin
							state_d = S_INSERT;
						end
					end else if (req.kind == rhh_pkg::KIND_FIND ||
					             req.kind == rhh_pkg::KIND_REMOVE) begin
						state_d = S_FIND;
					end else begin
						status_d = rhh_pkg::ST_NOTFOUND;
						state_d  = S_DONE;
					end
				end
			end
			S_INSERT: begin
				mem_ra = pos_q + 1'b1;
				if (mem_rpay.len == 4'd0) begin
					mem_we  = 1'b1;
					occ_d   = occ_q + 1'b1;
					state_d = S_DONE;
				end else begin
					if (cd_q > mem_rdist) begin
						mem_we = 1'b1;
						car_d  = mem_rpay;
						ncd    = mem_rdist + 1'b1;
					end else begin
						ncd = cd_q + 1'b1;
					end
					cd_d = ncd;
					if (ncd > maxd_q) begin
						maxd_d = ncd;
					end
					pos_d = pos_q + 1'b1;
				end
			end
			S_FIND: begin
				mem_ra = pos_q + 1'b1;
				if (match) begin
					rdata_d = mem_rpay.data;
					hit_d   = pos_q;
					if (kind_q == rhh_pkg::KIND_REMOVE) begin
						fit_d   = pos_q;
						pos_d   = pos_q + 1'b1;
						cnt_d   = '0;
						state_d = S_SHIFT;
					end else begin
						state_d = S_DONE;
					end
				end else if (cnt_q == {1'b0, maxd_q}) begin
					status_d = rhh_pkg::ST_NOTFOUND;
					state_d  = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
					pos_d = pos_q + 1'b1;
				end
			end
			S_SHIFT: begin
				mem_ra = pos_q + 1'b1;
				mem_we = 1'b1;
				mem_wa = fit_q;
				if (mem_rpay.len == 4'd0 || mem_rdist == '0 || cnt_q == DEPTH_CNT) begin
					mem_wpay = empty;
					occ_d    = occ_q - 1'b1;
					state_d  = S_DONE;
				end else begin
					mem_wpay  = mem_rpay;
					mem_wdist = mem_rdist - 1'b1;
					fit_d     = pos_q;
					pos_d     = pos_q + 1'b1;
					cnt_d     = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		hit_x = {8'd0, hit_q};
		occ_x = {9'd0, occ_q};
		max_x = {8'd0, maxd_q};
		res.status      = status_q;
		res.result_data = rdata_q;
		res.hit_slot    = hit_x[7:0];
		res.entry_count = (occ_x > (AW+10)'(511)) ? 9'd511 : occ_x[8:0];
		res.max_distance = (max_x > (AW+8)'(255)) ? 8'd255 : max_x[7:0];
	end

endmodule

// ===== rtl/robin_hood_hash_table.sv =====
// Robin Hood hash table with linear probing over TABLE_DEPTH slots held in one
// synchronous memory. After reset the block clears the memory and stalls its
// input meanwhile. Each item then walks its slots one per cycle through the
// single memory read port: an insert its probe length, a find up to
// max_distance + 1 slots, and a remove adds the backward-shift length. Items
// are handled one at a time; results go out through a registered output stage.
module robin_hood_hash_table #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BYTES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] hash,
	input  logic [63:0] key,
	input  logic [3:0]  key_len,
	input  logic [31:0] data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_data,
	output logic [7:0]  hit_slot,
	output logic [8:0]  entry_count,
	output logic [7:0]  max_distance
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = $bits(rhh_pkg::rhh_payload_t);

	rhh_pkg::rhh_req_t     req;
	rhh_pkg::rhh_result_t  res, out_q;
	rhh_pkg::rhh_payload_t wpay, rpay;
	logic                  res_valid, res_take, out_valid_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa, mem_ra, wdist, rdist;
	logic [PW+AW-1:0]      mem_rd;

	assign req.kind    = kind;
	assign req.hash    = hash;
	assign req.key     = key;
	assign req.key_len = key_len;
	assign req.data    = data;

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign rpay  = mem_rd[PW+AW-1:AW];
	assign rdist = mem_rd[AW-1:0];

	rhh_mem #(
		.AW(AW),
		.DW(PW + AW)
	) u_mem (
		.clk(clk),
		.we (mem_we),
		.wa (mem_wa),
		.wd ({wpay, wdist}),
		.ra (mem_ra),
		.rd (mem_rd)
	);

	rhh_engine #(
		.AW       (AW),
		.KEY_BYTES(KEY_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(in_valid),
		.req      (req),
		.req_stall(in_stall),
		.res_valid(res_valid),
		.res      (res),
		.res_take (res_take),
		.mem_we   (mem_we),
		.mem_wa   (mem_wa),
		.mem_wpay (wpay),
		.mem_wdist(wdist),
		.mem_ra   (mem_ra),
		.mem_rpay (rpay),
		.mem_rdist(rdist)
	);

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign result_data  = out_q.result_data;
	assign hit_slot     = out_q.hit_slot;
	assign entry_count  = out_q.entry_count;
	assign max_distance = out_q.max_distance;

endmodule

// ===== test/tb_robin_hood_hash_table.sv =====
// Self-checking testbench for robin_hood_hash_table: directed and random inserts,
// finds and removes, checked against a behavioural model of the probing table.
// Depends on rhh_pkg and the robin_hood_hash_table RTL only.
module tb_robin_hood_hash_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = 256;
	localparam int KEY_BYTES = 8;
	localparam int LIMIT     = 4000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] hash;
	logic [63:0] key;
	logic [3:0]  key_len;
	logic [31:0] data;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] result_data;
	logic [7:0]  hit_slot;
	logic [8:0]  entry_count;
	logic [7:0]  max_distance;

	robin_hood_hash_table #(.TABLE_DEPTH(DEPTH), .KEY_BYTES(KEY_BYTES)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .hash(hash), .key(key), .key_len(key_len), .data(data),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.result_data(result_data), .hit_slot(hit_slot), .entry_count(entry_count),
		.max_distance(max_distance)
	);

	typedef struct {
		logic [31:0] hash;
		logic [63:0] key;
		logic [3:0]  len;
	} stored_key_t;

	// Model of the table contents.
	logic [63:0] slot_key  [DEPTH];
	logic [31:0] slot_hash [DEPTH];
	logic [31:0] slot_data [DEPTH];
	logic [3:0]  slot_len  [DEPTH];
	int          slot_dist [DEPTH];
	int          longest_probe;
	int          live_entries;

	rhh_pkg::rhh_result_t pending_results[$];
	stored_key_t          known_keys[$];
	int                   failures;
	int                   cycle_count;
	bit                   sink_idle_on;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	function automatic logic [63:0] masked_key(logic [63:0] k, logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < len) begin
				m[b*8 +: 8] = k[b*8 +: 8];
			end
		end
		return m;
	endfunction

	function automatic rhh_pkg::rhh_result_t table_step(logic [1:0] op, logic [31:0] h,
			logic [63:0] k_in, logic [3:0] len, logic [31:0] d);
		rhh_pkg::rhh_result_t r;
		logic [63:0] k, tk;
		logic [31:0] th, td;
		logic [3:0]  tl;
		logic [7:0]  pos, fit, nxt;
		int          cd, td_dist, scan;
		bit          found;
		r = '0;
		k = masked_key(k_in, len);
		found = 1'b0;
		if (len == 0 || len > KEY_BYTES) begin
			r.status = rhh_pkg::ST_BADLEN;
		end else if (op == rhh_pkg::KIND_INSERT) begin
			if (live_entries >= DEPTH) begin
				r.status = rhh_pkg::ST_FULL;
			end else begin
				pos = h[7:0];
				cd = 0;
				for (int i = 0; i < DEPTH && slot_len[pos] != 0; i++) begin
					if (cd > slot_dist[pos]) begin
						tk = slot_key[pos]; th = slot_hash[pos]; td = slot_data[pos];
						tl = slot_len[pos]; td_dist = slot_dist[pos];
						slot_key[pos] = k; slot_hash[pos] = h; slot_data[pos] = d;
						slot_len[pos] = len; slot_dist[pos] = cd;
						k = tk; h = th; d = td; len = tl; cd = td_dist;
					end
					cd++;
					if (cd > longest_probe) longest_probe = cd;
					pos++;
				end
				slot_key[pos] = k; slot_hash[pos] = h; slot_data[pos] = d;
				slot_len[pos] = len; slot_dist[pos] = cd;
				live_entries++;
			end
		end else if (op == rhh_pkg::KIND_FIND || op == rhh_pkg::KIND_REMOVE) begin
			pos = h[7:0];
			scan = longest_probe + 1;
			if (scan > DEPTH) scan = DEPTH;
			for (int i = 0; i < scan && !found; i++) begin
				if (slot_len[pos] == len && slot_hash[pos] == h && slot_key[pos] == k) begin
					found = 1'b1;
				end else begin
					pos++;
				end
			end
			if (!found) begin
				r.status = rhh_pkg::ST_NOTFOUND;
			end else begin
				r.result_data = slot_data[pos];
				r.hit_slot = pos;
				if (op == rhh_pkg::KIND_REMOVE) begin
					fit = pos;
					nxt = pos + 8'd1;
					slot_len[pos] = '0;
					for (int i = 0; i < DEPTH; i++) begin
						if (slot_len[nxt] == 0 || slot_dist[nxt] == 0) break;
						slot_key[fit] = slot_key[nxt]; slot_hash[fit] = slot_hash[nxt];
						slot_data[fit] = slot_data[nxt]; slot_len[fit] = slot_len[nxt];
						slot_dist[fit] = slot_dist[nxt] - 1;
						slot_len[nxt] = '0;
						fit = nxt;
						nxt++;
					end
					live_entries--;
				end
			end
		end else begin
			r.status = rhh_pkg::ST_NOTFOUND;
		end
		r.entry_count = (live_entries > 511) ? 9'd511 : 9'(live_entries);
		r.max_distance = (longest_probe > 255) ? 8'd255 : 8'(longest_probe);
		return r;
	endfunction

	task automatic send_item(logic [1:0] op, logic [31:0] h, logic [63:0] k, logic [3:0] len,
			logic [31:0] d);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= op; hash <= h; key <= k; key_len <= len; data <= d;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) break;
		end
		pending_results.push_back(table_step(op, h, k, len, d));
	endtask

	task automatic insert_new(logic [31:0] h);
		stored_key_t s;
		s.hash = h;
		s.key = {$urandom, $urandom};
		s.len = 4'($urandom_range(1, KEY_BYTES));
		known_keys.push_back(s);
		send_item(rhh_pkg::KIND_INSERT, s.hash, s.key, s.len, $urandom);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_bad_lengths();
		send_item(rhh_pkg::KIND_INSERT, 32'h0, '1, 4'd0, 32'hFFFF_FFFF);
		send_item(rhh_pkg::KIND_FIND, 32'hFFFF_FFFF, '1, 4'd9, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'h1234_5678, '0, 4'd15, 32'h0);
		send_item(2'd3, 32'h0, '0, 4'd0, 32'h0);
		send_item(2'd3, 32'hFFFF_FFFF, '1, 4'd8, 32'hFFFF_FFFF);
	endtask

	task automatic test_basic_ops();
		send_item(rhh_pkg::KIND_INSERT, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
		send_item(rhh_pkg::KIND_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFAB, 4'd1, 32'h0);
		// Same hash and slot near the top so the cluster wraps past slot 255.
		send_item(rhh_pkg::KIND_INSERT, 32'hFFFF_FFFF, 64'h1122, 4'd2, 32'hA5A5_5A5A);
		send_item(rhh_pkg::KIND_INSERT, 32'h0000_01FE, 64'h33, 4'd1, 32'h5A5A_A5A5);
		send_item(rhh_pkg::KIND_FIND, 32'hFFFF_FFFF, 64'h0000_0000_0000_00AB, 4'd1, 32'h0);
		send_item(rhh_pkg::KIND_FIND, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
		send_item(rhh_pkg::KIND_FIND, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 32'h0);
		// A duplicate key goes in twice; find and remove hit the first copy.
		send_item(rhh_pkg::KIND_INSERT, 32'hFFFF_FFFF, 64'h1122, 4'd2, 32'h0BAD_F00D);
		send_item(rhh_pkg::KIND_FIND, 32'hFFFF_FFFF, 64'hFF00_1122, 4'd2, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 64'h1122, 4'd2, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 64'h1122, 4'd2, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 64'h1122, 4'd2, 32'h0);
		send_item(rhh_pkg::KIND_FIND, 32'h0000_01FE, 64'h33, 4'd1, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 64'hAB, 4'd1, 32'h0);
		send_item(rhh_pkg::KIND_REMOVE, 32'h0000_01FE, 64'h33, 4'd1, 32'h0);
	endtask

	task automatic test_full_table();
		int idx;
		while (live_entries < DEPTH) insert_new($urandom);
		send_item(rhh_pkg::KIND_INSERT, $urandom, {$urandom, $urandom}, 4'd8, $urandom);
		repeat (80) begin
			idx = $urandom_range(0, known_keys.size() - 1);
			send_item(rhh_pkg::KIND_REMOVE, known_keys[idx].hash, known_keys[idx].key,
				known_keys[idx].len, $urandom);
			known_keys.delete(idx);
		end
	endtask

	task automatic test_random_mix();
		int pick, idx;
		logic [63:0] k;
		for (int n = 0; n < 60; n++) begin
			pick = $urandom_range(0, 99);
			if (live_entries > 220 && pick < 45) pick = 80;
			if (known_keys.size() == 0 && pick >= 45 && pick < 95) pick = 0;
			if (pick < 45) begin
				// Narrow home range builds long clusters and deep probes.
				insert_new({24'($urandom_range(0, 32'hFF_FFFF)), 8'($urandom_range(0, 47))});
			end else if (pick < 95) begin
				idx = $urandom_range(0, known_keys.size() - 1);
				k = known_keys[idx].key;
				if ($urandom_range(0, 1)) k = k ^ ({$urandom, $urandom} &
					~masked_key('1, known_keys[idx].len));
				if (pick < 70) begin
					send_item(rhh_pkg::KIND_FIND, known_keys[idx].hash, k,
						known_keys[idx].len, $urandom);
				end else begin
					send_item(rhh_pkg::KIND_REMOVE, known_keys[idx].hash, k,
						known_keys[idx].len, $urandom);
					known_keys.delete(idx);
				end
			end else begin
				send_item(2'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
					4'($urandom_range(0, 15)), $urandom);
			end
		end
	endtask

	initial begin
		int n;
		forever begin
			n = (!sink_idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			out_stall <= (n != 0);
			if (n != 0) begin
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			forever begin
				@(posedge clk);
				if (out_valid && !out_stall) break;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		rhh_pkg::rhh_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, status %0h", $time, status);
				failures++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", 32'(e.status), 32'(status));
				check_field("result_data", e.result_data, result_data);
				check_field("hit_slot", 32'(e.hit_slot), 32'(hit_slot));
				check_field("entry_count", 32'(e.entry_count), 32'(entry_count));
				check_field("max_distance", 32'(e.max_distance), 32'(max_distance));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		failures = 0;
		cycle_count = 0;
		longest_probe = 0;
		live_entries = 0;
		sink_idle_on = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_len[i] = '0;
			slot_dist[i] = 0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0; hash = '0; key = '0; key_len = '0; data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_bad_lengths();
		sink_idle_on = 1'b1;
		test_basic_ops();
		test_full_table();
		test_random_mix();
		in_valid <= 1'b0;
		drain();
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
